// ===== src/tlf_pkg.sv =====
`default_nettype none
package tlf_pkg;

	localparam logic [1:0] OP_TEXT = 2'd0;
	localparam logic [1:0] OP_MARK = 2'd1;
	localparam logic [1:0] OP_FILE = 2'd2;

	localparam logic [1:0] REG_TAB_SIZE      = 2'd0;
	localparam logic [1:0] REG_SHOW_BLANK    = 2'd1;
	localparam logic [1:0] REG_TOTALS_ENABLE = 2'd2;

	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_DEL   = 8'd127;
	localparam logic [7:0] CHAR_CARET = 8'h5E;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [4:0] BIT_MASK   = 5'h1F;

	localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

	localparam logic [5:0] TAB_RESET = 6'd8;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  byte_value;
		logic [15:0] line_index;
	} item_t;

	typedef struct packed {
		logic [23:0] line_number;
		logic [23:0] total_line;
		logic [15:0] pad_spaces;
		logic        char_valid;
		logic [7:0]  char_code;
		logic        end_of_line;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROC,
		ST_CARET
	} state_t;

endpackage
`default_nettype wire

// ===== src/tlf_ram.sv =====
`default_nettype none
module tlf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/tab_expand_caret_line_filter.sv =====
`default_nettype none
// Tab-expanding, caret-escaping line filter.
// item channel (item_valid/item_ready, payload item): text bytes, line marks,
// new-file events. result channel (result_valid/result_ready, payload result):
// pad-and-character beats and end-of-line beats; last flags the final beat
// of an item. cfg_we/cfg_index/cfg_data write tab_size, show_blank or
// totals_enable, as cfg_index selects.
// Each item is accepted in ST_IDLE, where the mark memory is read; then
// ST_PROC updates state and, when a beat is due, loads the output register.
// A control or high byte sends its second beat from ST_CARET. The output register holds a beat while
// the next item is accepted; if it is still full when a new beat is due, the
// block waits for result_ready.
// After reset the mark memory is swept to zero, one word a cycle, over all
// MARK_WORDS words (2048 by default) with item_ready low. A tab_size write
// recomputes the tab phase of the target column with item_ready low.
module tab_expand_caret_line_filter #(
	parameter int MARK_WORDS  = 2048,
	parameter int COLUMN_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire tlf_pkg::item_t  item,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output tlf_pkg::result_t     result,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [5:0]      cfg_data
);

	localparam int AW  = (MARK_WORDS > 1) ? $clog2(MARK_WORDS) : 1;
	localparam int RCW = $clog2(COLUMN_BITS);
	localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

	tlf_pkg::state_t state_q, state_n;

	logic [5:0] tab_size_q;
	logic       show_blank_q;
	logic       totals_enable_q;

	logic                   any_marked_q;
	logic [23:0]            file_cnt_q;
	logic [23:0]            total_cnt_q;
	logic                   at_ls_q;
	logic [COLUMN_BITS-1:0] cur_q;
	logic [COLUMN_BITS-1:0] tgt_q;
	logic [5:0]             phase_q;
	logic                   had_q;
	logic                   sel_q;

	tlf_pkg::item_t item_s1;
	logic [AW-1:0]  addr_s1;
	logic           word_ok_s1;
	logic [4:0]     bit_s1;

	logic [AW-1:0] clr_cnt_q;

	logic                   rem_busy_q;
	logic [RCW-1:0]         rem_cnt_q;
	logic [5:0]             rem_acc_q;
	logic [COLUMN_BITS-1:0] rem_sh_q;
	logic [6:0]             rem_v;
	logic [5:0]             rem_next;

	tlf_pkg::result_t out_q;
	logic             out_valid_q;
	tlf_pkg::result_t pend_q;

	logic        accept;
	logic        out_free;
	logic [5:0]  t_eff;
	logic [31:0] rd_word32;
	logic [23:0] rd_idx;
	logic [4:0]  rd_bit;
	logic [31:0] mem_rdata;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;

	// processing stage
	logic                   commit;
	logic                   need0, need1;
	tlf_pkg::result_t       r0, r1;
	logic [23:0]            fc_e, tc_e;
	logic                   sel_e, had_e;
	logic [COLUMN_BITS-1:0] cur_e, tgt_e;
	logic [5:0]             ph_e, ph_inc;
	logic                   memsel;
	logic [23:0]            fc_n, tc_n;
	logic                   als_n, had_n, sel_n, any_n;
	logic [COLUMN_BITS-1:0] cur_n, tgt_n;
	logic [5:0]             ph_n;
	logic [COLUMN_BITS-1:0] pad;
	logic [15:0]            pad16;
	logic [COLUMN_BITS:0]   nx;
	logic [23:0]            tl_out;

	assign t_eff    = (tab_size_q == 6'd0) ? 6'd1 : tab_size_q;
	assign out_free = !out_valid_q || result_ready;
	assign item_ready = (state_q == tlf_pkg::ST_IDLE) && !rem_busy_q;
	assign accept   = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result   = out_q;

	// read address at acceptance
	always_comb begin
		rd_idx = (file_cnt_q < tlf_pkg::CNT_MAX) ? file_cnt_q : (tlf_pkg::CNT_MAX - 24'd1);
		if (item.opcode == tlf_pkg::OP_MARK) begin
			rd_word32 = 32'(item.line_index[15:5]);
			rd_bit    = item.line_index[4:0];
		end else begin
			rd_word32 = 32'(rd_idx[23:5]);
			rd_bit    = rd_idx[4:0] & tlf_pkg::BIT_MASK;
		end
	end

	assign mem_we    = (state_q == tlf_pkg::ST_CLEAR) ||
		(commit && item_s1.opcode == tlf_pkg::OP_MARK && word_ok_s1);
	assign mem_waddr = (state_q == tlf_pkg::ST_CLEAR) ? clr_cnt_q : addr_s1;
	assign mem_wdata = (state_q == tlf_pkg::ST_CLEAR) ? 32'd0 :
		(mem_rdata | (32'd1 << bit_s1));

	tlf_ram #(
		.WIDTH(32),
		.DEPTH(MARK_WORDS),
		.AW   (AW)
	) u_mark_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(rd_word32[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_comb begin
		memsel = !any_marked_q || (word_ok_s1 && mem_rdata[bit_s1]);
		if (at_ls_q && item_s1.opcode == tlf_pkg::OP_TEXT) begin
			fc_e  = (file_cnt_q < tlf_pkg::CNT_MAX) ? file_cnt_q + 24'd1 : file_cnt_q;
			tc_e  = (totals_enable_q && total_cnt_q < tlf_pkg::CNT_MAX) ?
				total_cnt_q + 24'd1 : total_cnt_q;
			sel_e = memsel;
			had_e = 1'b0;
			cur_e = '0;
			tgt_e = '0;
			ph_e  = 6'd0;
		end else begin
			fc_e  = file_cnt_q;
			tc_e  = total_cnt_q;
			sel_e = sel_q;
			had_e = had_q;
			cur_e = cur_q;
			tgt_e = tgt_q;
			ph_e  = phase_q;
		end
		ph_inc = (ph_e + 6'd1 == t_eff) ? 6'd0 : ph_e + 6'd1;
		pad    = tgt_e - cur_e;
		pad16  = (32'(pad) > 32'd65535) ? 16'hFFFF : 16'(pad);
		nx     = {1'b0, tgt_e} + (COLUMN_BITS+1)'(7'(t_eff) - 7'(ph_e));
		tl_out = totals_enable_q ? tc_e : 24'd0;

		fc_n  = fc_e;
		tc_n  = tc_e;
		als_n = at_ls_q;
		had_n = had_e;
		sel_n = sel_e;
		cur_n = cur_e;
		tgt_n = tgt_e;
		ph_n  = ph_e;
		any_n = any_marked_q;
		need0 = 1'b0;
		need1 = 1'b0;
		r0 = '{line_number: fc_e, total_line: tl_out, pad_spaces: 16'd0, char_valid: 1'b0,
			char_code: 8'd0, end_of_line: 1'b0, last: 1'b1};
		r1 = r0;
		r1.char_valid = 1'b1;
		r1.char_code  = item_s1.byte_value + tlf_pkg::CHAR_A;

		unique case (item_s1.opcode)
			tlf_pkg::OP_MARK: begin
				if (word_ok_s1) begin
					any_n = 1'b1;
				end
			end
			tlf_pkg::OP_FILE: begin
				need0 = !at_ls_q && sel_q && had_q;
				r0.end_of_line = 1'b1;
				fc_n  = 24'd0;
				als_n = 1'b1;
				cur_n = '0;
				tgt_n = '0;
				ph_n  = 6'd0;
				had_n = 1'b0;
				sel_n = 1'b0;
			end
			tlf_pkg::OP_TEXT: begin
				als_n = 1'b0;
				if (item_s1.byte_value == tlf_pkg::CHAR_LF) begin
					need0 = sel_e && (had_e || show_blank_q);
					r0.end_of_line = 1'b1;
					als_n = 1'b1;
				end else if (item_s1.byte_value == tlf_pkg::CHAR_SPACE) begin
					if (tgt_e < COL_MAX) begin
						tgt_n = tgt_e + 1'b1;
					end
					ph_n = ph_inc;
				end else if (item_s1.byte_value == tlf_pkg::CHAR_TAB) begin
					tgt_n = (nx > {1'b0, COL_MAX}) ? COL_MAX : nx[COLUMN_BITS-1:0];
					ph_n  = 6'd0;
				end else begin
					r0.pad_spaces = pad16;
					if (sel_e) begin
						if (item_s1.byte_value > tlf_pkg::CHAR_SPACE &&
								item_s1.byte_value < tlf_pkg::CHAR_DEL) begin
							need0 = 1'b1;
							r0.char_valid = 1'b1;
							r0.char_code  = item_s1.byte_value;
							had_n = 1'b1;
						end else if (item_s1.byte_value == tlf_pkg::CHAR_DEL) begin
							need0 = (pad != '0);
							had_n = had_e || (pad != '0);
						end else begin
							need0 = 1'b1;
							need1 = 1'b1;
							r0.char_valid = 1'b1;
							r0.char_code  = tlf_pkg::CHAR_CARET;
							r0.last = 1'b0;
							had_n = 1'b1;
						end
					end
					cur_n = (tgt_e < COL_MAX) ? tgt_e + 1'b1 : COL_MAX;
					tgt_n = cur_n;
					ph_n  = ph_inc;
				end
			end
			default: begin
			end
		endcase
		commit = (state_q == tlf_pkg::ST_PROC) && (!need0 || out_free);
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tlf_pkg::ST_CLEAR: begin
				if (clr_cnt_q == AW'(MARK_WORDS - 1)) begin
					state_n = tlf_pkg::ST_IDLE;
				end
			end
			tlf_pkg::ST_IDLE: begin
				if (accept) begin
					state_n = tlf_pkg::ST_PROC;
				end
			end
			tlf_pkg::ST_PROC: begin
				if (commit) begin
					state_n = need1 ? tlf_pkg::ST_CARET : tlf_pkg::ST_IDLE;
				end
			end
			tlf_pkg::ST_CARET: begin
				if (out_free) begin
					state_n = tlf_pkg::ST_IDLE;
				end
			end
			default: state_n = tlf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlf_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == tlf_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// config registers and tab phase recompute
	assign rem_v    = {rem_acc_q, rem_sh_q[COLUMN_BITS-1]};
	assign rem_next = (rem_v >= {1'b0, t_eff}) ? 6'(rem_v - {1'b0, t_eff}) : rem_v[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_size_q      <= tlf_pkg::TAB_RESET;
			show_blank_q    <= 1'b1;
			totals_enable_q <= 1'b0;
			rem_busy_q      <= 1'b0;
			rem_cnt_q       <= '0;
		end else begin
			if (cfg_we && cfg_index == tlf_pkg::REG_TAB_SIZE) begin
				rem_busy_q <= 1'b1;
				rem_cnt_q  <= '0;
			end else if (rem_busy_q) begin
				rem_cnt_q <= rem_cnt_q + 1'b1;
				if (rem_cnt_q == RCW'(COLUMN_BITS - 1)) begin
					rem_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					tlf_pkg::REG_TAB_SIZE:      tab_size_q      <= cfg_data;
					tlf_pkg::REG_SHOW_BLANK:    show_blank_q    <= cfg_data[0];
					tlf_pkg::REG_TOTALS_ENABLE: totals_enable_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we && cfg_index == tlf_pkg::REG_TAB_SIZE) begin
			rem_acc_q <= 6'd0;
			rem_sh_q  <= tgt_q;
		end else if (rem_busy_q) begin
			rem_acc_q <= rem_next;
			rem_sh_q  <= {rem_sh_q[COLUMN_BITS-2:0], 1'b0};
		end
		if (accept) begin
			item_s1    <= item;
			addr_s1    <= rd_word32[AW-1:0];
			word_ok_s1 <= rd_word32 < 32'(MARK_WORDS);
			bit_s1     <= rd_bit;
		end
		if (commit && need1) begin
			pend_q <= r1;
		end
		if (commit && need0) begin
			out_q <= r0;
		end else if (state_q == tlf_pkg::ST_CARET && out_free) begin
			out_q <= pend_q;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_marked_q <= 1'b0;
			file_cnt_q   <= 24'd0;
			total_cnt_q  <= 24'd0;
			at_ls_q      <= 1'b1;
			cur_q        <= '0;
			tgt_q        <= '0;
			phase_q      <= 6'd0;
			had_q        <= 1'b0;
			sel_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit) begin
				any_marked_q <= any_n;
				file_cnt_q   <= fc_n;
				total_cnt_q  <= tc_n;
				at_ls_q      <= als_n;
				cur_q        <= cur_n;
				tgt_q        <= tgt_n;
				phase_q      <= ph_n;
				had_q        <= had_n;
				sel_q        <= sel_n;
			end else if (rem_busy_q && rem_cnt_q == RCW'(COLUMN_BITS - 1)) begin
				phase_q <= rem_next;
			end
			if ((commit && need0) || (state_q == tlf_pkg::ST_CARET && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_phase_below_tab: assert property (@(posedge clk) disable iff (!arst_n)
		!rem_busy_q |-> phase_q < t_eff)
		else $error("tab phase out of range");

	a_target_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q >= cur_q)
		else $error("target column behind current column");

	a_eol_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_line |->
			result.pad_spaces == 16'd0 && !result.char_valid && result.last)
		else $error("end-of-line beat carries data");

	a_caret_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.char_code == tlf_pkg::CHAR_CARET)
		else $error("non-final beat is not a caret");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlf_pkg::ST_CARET |=> state_q != tlf_pkg::ST_PROC)
		else $error("item taken during second beat");

endmodule
`default_nettype wire
